// ----- sv/dsf_pkg.sv -----
package dsf_pkg;

    // Operation carried by an input item.
    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_PAYLOAD = 2'd1,
        OP_END     = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    // Fixed widths of the result fields.
    localparam int OFS_BITS  = 20;
    localparam int SLOT_BITS = 4;

    // Header constants.
    localparam logic [7:0]  FLAG_CHAIN     = 8'h40;
    localparam logic [7:0]  FLAG_SAME_CORR = 8'h10;
    localparam logic [7:0]  DSS_MAGIC      = 8'hD0;
    localparam logic [15:0] MAX_SEG_LEN    = 16'h7FFF;
    localparam logic [15:0] OBJ_LEN_ADJ    = 16'd6;

    // Byte positions inside a ten-byte header.
    localparam int HDR_LEN_OFS     = 0;
    localparam int HDR_FLAGS_OFS   = 3;
    localparam int HDR_OBJ_LEN_OFS = 6;

    // Last result slot of each kind of item.
    localparam logic [SLOT_BITS-1:0] START_LAST_SLOT = 4'd10;
    localparam logic [SLOT_BITS-1:0] END_LAST_SLOT   = 4'd3;
    localparam logic [SLOT_BITS-1:0] ONE_LAST_SLOT   = 4'd0;

    // Result slots of a start item that carry header bytes.
    localparam logic [SLOT_BITS-1:0] SLOT_CHAIN   = 4'd0;
    localparam logic [SLOT_BITS-1:0] SLOT_MAGIC   = 4'd3;
    localparam logic [SLOT_BITS-1:0] SLOT_TYPE    = 4'd4;
    localparam logic [SLOT_BITS-1:0] SLOT_CORR_HI = 4'd5;
    localparam logic [SLOT_BITS-1:0] SLOT_CORR_LO = 4'd6;
    localparam logic [SLOT_BITS-1:0] SLOT_CP_HI   = 4'd9;
    localparam logic [SLOT_BITS-1:0] SLOT_CP_LO   = 4'd10;

    // Result slots of an end item.
    localparam logic [SLOT_BITS-1:0] SLOT_LEN_HI = 4'd0;
    localparam logic [SLOT_BITS-1:0] SLOT_LEN_LO = 4'd1;
    localparam logic [SLOT_BITS-1:0] SLOT_OBJ_HI = 4'd2;

    typedef struct packed {
        t_op         op;
        logic [7:0]  frame_type;
        logic [15:0] correlation_id;
        logic [15:0] code_point;
        logic [7:0]  data_byte;
    } t_in_item;

    typedef struct packed {
        logic                write_valid;
        logic [OFS_BITS-1:0] write_offset;
        logic [7:0]          write_value;
        logic                error;
        logic                last;
    } t_out_item;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        t_in_item             item;
        logic [SLOT_BITS-1:0] last_slot;
    } t_cmd;

    // Header byte that a start item appends in a given slot.
    function automatic logic [7:0] header_byte(input logic [SLOT_BITS-1:0] slot,
                                               input t_in_item item);
        logic [7:0] value;
        value = 8'h00;
        case (slot)
            SLOT_MAGIC:   value = DSS_MAGIC;
            SLOT_TYPE:    value = item.frame_type;
            SLOT_CORR_HI: value = item.correlation_id[15:8];
            SLOT_CORR_LO: value = item.correlation_id[7:0];
            SLOT_CP_HI:   value = item.code_point[15:8];
            SLOT_CP_LO:   value = item.code_point[7:0];
            default:      value = 8'h00;
        endcase
        return value;
    endfunction

endpackage

// ----- sv/dss_segment_framer_core.sv -----
// Segment framer: each transfer in is a start, payload, end or clear command and
// yields a short sequence of results, mostly buffer byte writes, with last set on
// the final one. A payload item yields one result, a start item eleven (chain
// patch plus ten header bytes), an end item four and a clear item one; the
// back-end sequencer issues one result per cycle while the result queue has room.
// With both queues empty, the first result of an item is registered in the command
// queue and then in the result queue before it reaches the result ports. A command
// queue of CMD_DEPTH entries sits in front of the sequencer, so up to CMD_DEPTH - 1
// further items are accepted at one per cycle while a header is still being sent,
// and a two-entry result queue lets the sequencer keep writing at one per cycle
// while pop is held high; when results are not popped the sequencer stalls, and
// then the input does. Errors (buffer full, segment longer than 0x7FFF, end without
// a header) are sticky, suppress all writes and clear only with a clear command or a reset.
module dss_segment_framer_core import dsf_pkg::*; #(
    parameter int ADDR_BITS = 20,
    parameter int CMD_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    input  t_in_item  i_item,
    output logic      full,
    output logic      empty,
    output t_out_item o_result,
    input  logic      pop
);

    logic      cmd_valid;
    t_cmd      cmd;
    logic      cmd_pop;
    logic      res_full;
    logic      res_valid;
    t_out_item res;

    // Accept and classify commands.
    dsf_front #(
        .CMD_DEPTH (CMD_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // Expand commands into buffer writes.
    dsf_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Hold results until they are popped.
    dsf_result_queue u_result_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_res_full  (res_full),
        .o_empty     (empty),
        .o_result    (o_result),
        .i_pop       (pop)
    );

endmodule

// ----- sv/dsf_front.sv -----
module dsf_front import dsf_pkg::*; #(
    parameter int CMD_DEPTH = 4
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_item,
    output logic     o_full,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_pop
);

    localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    t_cmd             r_mem [CMD_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    t_cmd             cmd_in;
    logic             push_fire;
    logic             pop_fire;

    // Classify the item by the number of results it will produce.
    always_comb begin
        cmd_in      = '0;
        cmd_in.item = i_item;
        case (i_item.op)
            OP_START: cmd_in.last_slot = START_LAST_SLOT;
            OP_END:   cmd_in.last_slot = END_LAST_SLOT;
            default:  cmd_in.last_slot = ONE_LAST_SLOT;
        endcase
    end

    assign o_full      = (r_count == CNT_W'(CMD_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_mem[r_rd_ptr];
    assign push_fire   = i_push && !o_full;
    assign pop_fire    = i_cmd_pop && o_cmd_valid;

    // Command storage.
    always_ff @(posedge i_clk) begin
        if (push_fire) begin
            r_mem[r_wr_ptr] <= cmd_in;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_fire) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_fire) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push_fire, pop_fire})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- sv/dsf_result_queue.sv -----
module dsf_result_queue import dsf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_res_valid,
    input  t_out_item i_res,
    output logic      o_res_full,
    output logic      o_empty,
    output t_out_item o_result,
    input  logic      i_pop
);

    t_out_item  r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push_fire;
    logic       pop_fire;

    assign o_res_full = (r_count == 2'd2);
    assign o_empty    = (r_count == 2'd0);
    assign o_result   = r_mem[r_rd_ptr];
    assign push_fire  = i_res_valid && !o_res_full;
    assign pop_fire   = i_pop && !o_empty;

    // Result storage.
    always_ff @(posedge i_clk) begin
        if (push_fire) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

    // Two-entry queue control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push_fire) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop_fire) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push_fire, pop_fire})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- sv/dsf_back.sv -----
module dsf_back import dsf_pkg::*; #(
    parameter int ADDR_BITS = 20
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    input  logic      i_res_full,
    output logic      o_res_valid,
    output t_out_item o_res
);

    localparam int LW = (ADDR_BITS > 16) ? ADDR_BITS : 16;
    localparam int OW = (ADDR_BITS > OFS_BITS) ? ADDR_BITS : OFS_BITS;

    logic [ADDR_BITS-1:0] r_wp, n_wp;
    logic [ADDR_BITS-1:0] r_hs, n_hs;
    logic                 r_hv, n_hv;
    logic [7:0]           r_ptype, n_ptype;
    logic [15:0]          r_pcorr, n_pcorr;
    logic                 r_err, n_err;
    logic [SLOT_BITS-1:0] r_slot, n_slot;

    logic                 fire;
    logic                 is_last;
    logic                 full_pos;
    logic [ADDR_BITS-1:0] len;
    logic [LW-1:0]        len_ext;
    logic [15:0]          obj;
    logic                 too_long;
    logic [7:0]           flags;
    logic                 err_next;
    logic                 wr_en;
    logic [ADDR_BITS-1:0] wr_ofs;
    logic [OW-1:0]        wr_ofs_ext;
    logic [7:0]           wr_val;

    assign fire        = i_cmd_valid && !i_res_full;
    assign is_last     = (r_slot == i_cmd.last_slot);
    assign o_cmd_pop   = fire && is_last;
    assign o_res_valid = fire;

    // One result per cycle while the result queue has room: byte writes, header patches and state updates.
    always_comb begin
        n_wp     = r_wp;
        n_hs     = r_hs;
        n_hv     = r_hv;
        n_ptype  = r_ptype;
        n_pcorr  = r_pcorr;
        n_err    = r_err;
        n_slot   = r_slot;
        full_pos = (r_wp == '1);
        len      = r_wp - r_hs;
        len_ext  = LW'(len);
        obj      = len_ext[15:0] - OBJ_LEN_ADJ;
        too_long = (len_ext > LW'(MAX_SEG_LEN));
        flags    = r_ptype | FLAG_CHAIN |
                   ((r_pcorr == i_cmd.item.correlation_id) ? FLAG_SAME_CORR : 8'h00);
        err_next = r_err;
        wr_en    = 1'b0;
        wr_ofs   = '0;
        wr_val   = 8'h00;

        case (i_cmd.item.op)
            OP_START: begin
                if (r_slot == SLOT_CHAIN) begin
                    // Chain the previous header by rewriting its flags byte.
                    wr_en  = r_hv && !r_err;
                    wr_ofs = r_hs + ADDR_BITS'(HDR_FLAGS_OFS);
                    wr_val = flags;
                    if (fire) begin
                        n_hs    = r_wp;
                        n_hv    = 1'b1;
                        n_ptype = i_cmd.item.frame_type;
                        n_pcorr = i_cmd.item.correlation_id;
                    end
                end else begin
                    err_next = r_err || full_pos;
                    wr_en    = !err_next;
                    wr_ofs   = r_wp;
                    wr_val   = header_byte(r_slot, i_cmd.item);
                    if (fire && wr_en) begin
                        n_wp = r_wp + 1'b1;
                    end
                end
            end
            OP_PAYLOAD: begin
                err_next = r_err || full_pos;
                wr_en    = !err_next;
                wr_ofs   = r_wp;
                wr_val   = i_cmd.item.data_byte;
                if (fire && wr_en) begin
                    n_wp = r_wp + 1'b1;
                end
            end
            OP_END: begin
                // Write back segment length and object length, big endian.
                err_next = r_err || !r_hv || too_long;
                wr_en    = !err_next;
                case (r_slot)
                    SLOT_LEN_HI: begin
                        wr_ofs = r_hs + ADDR_BITS'(HDR_LEN_OFS);
                        wr_val = len_ext[15:8];
                    end
                    SLOT_LEN_LO: begin
                        wr_ofs = r_hs + ADDR_BITS'(HDR_LEN_OFS + 1);
                        wr_val = len_ext[7:0];
                    end
                    SLOT_OBJ_HI: begin
                        wr_ofs = r_hs + ADDR_BITS'(HDR_OBJ_LEN_OFS);
                        wr_val = obj[15:8];
                    end
                    default: begin
                        wr_ofs = r_hs + ADDR_BITS'(HDR_OBJ_LEN_OFS + 1);
                        wr_val = obj[7:0];
                    end
                endcase
            end
            OP_CLEAR: begin
                err_next = 1'b0;
                if (fire) begin
                    n_wp    = '0;
                    n_hs    = '0;
                    n_hv    = 1'b0;
                    n_ptype = 8'h00;
                    n_pcorr = 16'h0000;
                end
            end
            default: begin
                err_next = r_err;
            end
        endcase

        if (fire) begin
            n_err  = err_next;
            n_slot = is_last ? '0 : r_slot + 1'b1;
        end

        wr_ofs_ext         = OW'(wr_ofs);
        o_res              = '0;
        o_res.write_valid  = wr_en;
        o_res.write_offset = wr_en ? wr_ofs_ext[OFS_BITS-1:0] : '0;
        o_res.write_value  = wr_en ? wr_val : 8'h00;
        o_res.error        = err_next;
        o_res.last         = is_last;
    end

    // Framer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_hs    <= '0;
            r_hv    <= 1'b0;
            r_ptype <= 8'h00;
            r_pcorr <= 16'h0000;
            r_err   <= 1'b0;
            r_slot  <= '0;
        end else begin
            r_wp    <= n_wp;
            r_hs    <= n_hs;
            r_hv    <= n_hv;
            r_ptype <= n_ptype;
            r_pcorr <= n_pcorr;
            r_err   <= n_err;
            r_slot  <= n_slot;
        end
    end

`ifndef SYNTHESIS
    // A clear transfer returns the framer to its reset state.
    a_clear_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && (i_cmd.item.op == OP_CLEAR) |=> (r_wp == '0) && !r_err && !r_hv)
        else $error("clear did not reset framer state");

    // The error flag only drops through a clear.
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err && !(fire && (i_cmd.item.op == OP_CLEAR)) |=> r_err)
        else $error("error flag dropped without a clear");

    // No byte is written while the error flag is set.
    a_no_write_on_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && o_res.write_valid |-> !o_res.error)
        else $error("byte written under error");

    // The slot counter never runs past the last slot of the current command.
    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid |-> (r_slot <= i_cmd.last_slot))
        else $error("result slot past end of command");
`endif

endmodule
